[sv/osc_ser_pkg.sv]
// shared types and constants for the osc message serializer
// no dependencies
package osc_ser_pkg;

    // token codes on the opcode input
    localparam logic [2:0] OP_ADDR_BYTE = 3'd0;
    localparam logic [2:0] OP_END_ADDR  = 3'd1;
    localparam logic [2:0] OP_TAG_CHAR  = 3'd2;
    localparam logic [2:0] OP_END_TAGS  = 3'd3;
    localparam logic [2:0] OP_WORD      = 3'd4;
    localparam logic [2:0] OP_STR_BYTE  = 3'd5;
    localparam logic [2:0] OP_END_STR   = 3'd6;
    localparam logic [2:0] OP_START     = 3'd7;

    localparam int          MAX_MSG_BYTES_DEF = 256;
    localparam int          CMD_FIFO_DEPTH    = 4;
    localparam int          POS_W             = 13;
    localparam logic [7:0]  COMMA_CHAR        = 8'h2C;

    typedef enum logic [2:0] {
        K_BYTE,
        K_PAD,
        K_PAD_COMMA,
        K_WORD,
        K_START
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] data;
    } cmd_t;

endpackage

[sv/osc_message_serializer_top.sv]
// osc message serializer, top level
// depends on osc_ser_pkg, osc_ser_front, osc_ser_fifo, osc_ser_back
//
// tokens come in on the input channel (opcode, byte_value, word_value) with
// in_valid/in_ready; message bytes leave on the output channel with
// out_valid/out_ready, one byte per transaction, carrying its clamped offset, a flag
// on the final byte of each token and the sticky overflow flag.
// path: the first byte of a token passes the intake register, the queue,
// the sequencer and the output register before it shows on the output.
// throughput: the sequencer sends one byte per cycle while the output slot is
// free; a word token gives four bytes, a character one, end of tags or
// string one to four, end of address two to five, a start token no byte.
// the intake accepts one token per cycle while the command queue has room.
// reset clears the offset, the overflow flag, the queue and all valids.
// when the receiver holds out_ready low the output byte holds, the sequencer
// stops, and once the queue fills in_ready drops.
module osc_message_serializer_top #(
    parameter int MAX_MSG_BYTES  = osc_ser_pkg::MAX_MSG_BYTES_DEF,
    parameter int CMD_FIFO_DEPTH = osc_ser_pkg::CMD_FIFO_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  opcode,
    input  logic [7:0]  byte_value,
    input  logic [31:0] word_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic [7:0]  byte_position,
    output logic        last_of_run,
    output logic        overflow
);
    import osc_ser_pkg::*;

    logic push;
    logic push_ready;
    cmd_t push_cmd;
    logic pop_valid;
    logic pop;
    cmd_t pop_cmd;

    osc_ser_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .byte_value (byte_value),
        .word_value (word_value),
        .push       (push),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    osc_ser_fifo #(
        .DEPTH (CMD_FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_cmd    (pop_cmd)
    );

    osc_ser_back #(
        .MAX_MSG_BYTES (MAX_MSG_BYTES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop           (pop),
        .pop_cmd       (pop_cmd),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .byte_position (byte_position),
        .last_of_run   (last_of_run),
        .overflow      (overflow)
    );

endmodule

[sv/osc_ser_front.sv]
// token intake: registers one token and turns it into a back-end command
// depends on osc_ser_pkg
module osc_ser_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          opcode,
    input  logic [7:0]          byte_value,
    input  logic [31:0]         word_value,
    output logic                push,
    input  logic                push_ready,
    output osc_ser_pkg::cmd_t   push_cmd
);
    import osc_ser_pkg::*;

    logic front_valid_reg;
    cmd_t front_cmd_reg;
    cmd_t cmd_next;

    always_comb
    begin
        cmd_next.data = {24'd0, byte_value};
        unique case (opcode)
            OP_ADDR_BYTE, OP_TAG_CHAR, OP_STR_BYTE:
            begin
                cmd_next.kind = K_BYTE;
            end
            OP_END_ADDR:
            begin
                cmd_next.kind = K_PAD_COMMA;
            end
            OP_END_TAGS, OP_END_STR:
            begin
                cmd_next.kind = K_PAD;
            end
            OP_WORD:
            begin
                cmd_next.kind = K_WORD;
                cmd_next.data = word_value;
            end
            default:
            begin
                cmd_next.kind = K_START;
            end
        endcase
    end

    assign in_ready = !front_valid_reg || push_ready;
    assign push     = front_valid_reg;
    assign push_cmd = front_cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            front_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            front_cmd_reg <= cmd_next;
        end
    end

endmodule

[sv/osc_ser_fifo.sv]
// short command queue between intake and byte sequencer
// depends on osc_ser_pkg
module osc_ser_fifo #(
    parameter int DEPTH = osc_ser_pkg::CMD_FIFO_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                push_ready,
    input  osc_ser_pkg::cmd_t   push_cmd,
    output logic                pop_valid,
    input  logic                pop,
    output osc_ser_pkg::cmd_t   pop_cmd
);
    import osc_ser_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    cmd_t            entries_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != CntW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entries_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(DEPTH))
        else $error("command queue count above depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> push_ready || !pop_valid || (count_reg == CntW'(DEPTH)))
        else $error("push state inconsistent");

    a_ptrs_match_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue empty with pointers apart");

endmodule

[sv/osc_ser_back.sv]
// byte sequencer: expands commands into message bytes, tracks offset and overflow
// depends on osc_ser_pkg
module osc_ser_back #(
    parameter int MAX_MSG_BYTES = osc_ser_pkg::MAX_MSG_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop,
    input  osc_ser_pkg::cmd_t   pop_cmd,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic [7:0]          byte_position,
    output logic                last_of_run,
    output logic                overflow
);
    import osc_ser_pkg::*;

    localparam int ClampTop = (MAX_MSG_BYTES - 1 < 255) ? MAX_MSG_BYTES - 1 : 255;

    cmd_t             cmd_reg;
    logic             cmd_valid_reg;
    logic [1:0]       idx_reg;
    logic             comma_reg;
    logic [POS_W-1:0] pos_reg;
    logic             ovf_reg;
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic [7:0]       out_pos_reg;
    logic             out_last_reg;
    logic             out_ovf_reg;

    logic       slot_free;
    logic       is_start;
    logic       emit;
    logic       is_last;
    logic       done;
    logic [7:0] byte_sel;
    logic       ovf_now;
    logic [7:0] pos_clamped;

    assign slot_free = !out_valid_reg || out_ready;
    assign is_start  = (cmd_reg.kind == K_START);
    assign emit      = cmd_valid_reg && !is_start && slot_free;
    assign done      = cmd_valid_reg && (is_start || (emit && is_last));
    assign pop       = pop_valid && (!cmd_valid_reg || done);
    assign ovf_now   = ovf_reg || (pos_reg >= POS_W'(MAX_MSG_BYTES));
    assign pos_clamped = (pos_reg < POS_W'(ClampTop)) ? pos_reg[7:0] : ClampTop[7:0];

    always_comb
    begin
        byte_sel = 8'd0;
        is_last  = 1'b1;
        unique case (cmd_reg.kind)
            K_BYTE:
            begin
                byte_sel = cmd_reg.data[7:0];
            end
            K_WORD:
            begin
                // most significant byte first
                unique case (idx_reg)
                    2'd0:    byte_sel = cmd_reg.data[31:24];
                    2'd1:    byte_sel = cmd_reg.data[23:16];
                    2'd2:    byte_sel = cmd_reg.data[15:8];
                    default: byte_sel = cmd_reg.data[7:0];
                endcase
                is_last = (idx_reg == 2'd3);
            end
            K_PAD:
            begin
                is_last = (pos_reg[1:0] == 2'd3);
            end
            K_PAD_COMMA:
            begin
                byte_sel = comma_reg ? COMMA_CHAR : 8'd0;
                is_last  = comma_reg;
            end
            default:
            begin
                byte_sel = 8'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            idx_reg       <= '0;
            comma_reg     <= 1'b0;
            pos_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (slot_free)
            begin
                out_valid_reg <= emit;
            end
            if (emit)
            begin
                pos_reg <= pos_reg + 1'b1;
                ovf_reg <= ovf_now;
                // padding reached the boundary, comma goes next
                if (cmd_reg.kind == K_PAD_COMMA && !comma_reg && pos_reg[1:0] == 2'd3)
                begin
                    comma_reg <= 1'b1;
                end
            end
            if (cmd_valid_reg && is_start)
            begin
                pos_reg <= '0;
                ovf_reg <= 1'b0;
            end
            if (pop)
            begin
                cmd_valid_reg <= 1'b1;
                idx_reg       <= '0;
                comma_reg     <= 1'b0;
            end
            else
            begin
                if (done)
                begin
                    cmd_valid_reg <= 1'b0;
                end
                if (emit)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= pop_cmd;
        end
        if (emit)
        begin
            out_byte_reg <= byte_sel;
            out_pos_reg  <= pos_clamped;
            out_last_reg <= is_last;
            out_ovf_reg  <= ovf_now;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign byte_position = out_pos_reg;
    assign last_of_run   = out_last_reg;
    assign overflow      = out_ovf_reg;

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid_reg && is_start) |=> (pos_reg == '0) && !ovf_reg)
        else $error("start transaction did not clear position");

    a_pad_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && is_last && cmd_reg.kind == K_PAD) |-> (pos_reg[1:0] == 2'd3))
        else $error("padding ended off a word boundary");

    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (ovf_reg && !(cmd_valid_reg && is_start)) |=> ovf_reg)
        else $error("overflow flag dropped without start");

endmodule
